// ===== hdl/epwr_pkg.sv =====
// Shared constants for the echo pulse width ranger.
// No dependencies; the interfaces, the top level and the checker use it.
package epwr_pkg;

    localparam int COUNTER_BITS_DEF  = 16;
    localparam int OVERFLOW_BITS_DEF = 8;

    localparam int VALUE_W = 16;
    localparam int TICKS_W = 24;
    localparam int DIST_W  = 16;
    localparam int SCALE_W = 24;
    localparam int FRAC_W  = 24;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd5941;
    localparam logic [TICKS_W-1:0] TICKS_MAX   = {TICKS_W{1'b1}};
    localparam logic [DIST_W-1:0]  DIST_MAX    = {DIST_W{1'b1}};

endpackage

// ===== hdl/epwr_if.sv =====
// Channel interfaces of the echo pulse width ranger: timer events,
// results and the scale register write. Depends on epwr_pkg.
interface epwr_evt_if;
    logic                          valid;
    logic                          ready;
    logic                          overflow_event;
    logic                          capture_event;
    logic [epwr_pkg::VALUE_W-1:0]  capture_value;

    modport source(output valid, output overflow_event, output capture_event,
                   output capture_value, input ready);
    modport sink(input valid, input overflow_event, input capture_event,
                 input capture_value, output ready);
endinterface

interface epwr_res_if;
    logic                          valid;
    logic                          ready;
    logic [epwr_pkg::TICKS_W-1:0]  pulse_ticks;
    logic [epwr_pkg::DIST_W-1:0]   distance_cm;
    logic                          range_saturated;

    modport source(output valid, output pulse_ticks, output distance_cm,
                   output range_saturated, input ready);
    modport sink(input valid, input pulse_ticks, input distance_cm,
                 input range_saturated, output ready);
endinterface

interface epwr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [epwr_pkg::SCALE_W-1:0]  distance_scale_q24;

    modport source(output valid, output distance_scale_q24, input ready);
    modport sink(input valid, input distance_scale_q24, output ready);
endinterface

// ===== hdl/echo_pulse_width_ranger_top.sv =====
// Echo pulse width ranger: input capture pulse measurement and distance scaling.
// Depends on epwr_pkg and the channel interfaces in epwr_if.sv.

// Each transfer on i_evt is one timer event. The overflow flag is counted
// first (saturating at 2^OVERFLOW_BITS-1), then a capture either records the
// rise time or, on the falling capture that follows, produces one result on
// o_res with the pulse width in ticks, the distance in cm (width times the
// Q0.24 scale, saturated to 16 bits) and a flag set when the overflow count
// stood at its limit. Events without a capture and rising edges produce no
// result. The block takes one event per clock while o_res is not stalled: an
// input register and a width register, loaded by the state logic that updates
// the edge tracking and computes the width, feed the output register through
// the 24x24 scale multiply, so o_res.valid rises once the event has passed
// the input, width and output registers. The scale is written over i_cfg,
// which is always ready; write it only while no event is in flight.
module echo_pulse_width_ranger_top #(
    parameter int COUNTER_BITS  = epwr_pkg::COUNTER_BITS_DEF,
    parameter int OVERFLOW_BITS = epwr_pkg::OVERFLOW_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    epwr_evt_if.sink    i_evt,
    epwr_res_if.source  o_res,
    epwr_cfg_if.sink    i_cfg
);

    localparam int RAW_W = OVERFLOW_BITS + COUNTER_BITS + 1;
    localparam int TOT_W = (RAW_W > epwr_pkg::TICKS_W + 1) ? RAW_W
                                                           : epwr_pkg::TICKS_W + 1;
    localparam int PROD_W = epwr_pkg::TICKS_W + epwr_pkg::SCALE_W;
    localparam int FRAC_SHIFT = epwr_pkg::FRAC_W;
    localparam logic [OVERFLOW_BITS-1:0] TALLY_MAX = {OVERFLOW_BITS{1'b1}};

    // scale register
    logic [epwr_pkg::SCALE_W-1:0] r_scale;

    // input register
    logic                          r_in_v;
    logic                          r_in_ovf;
    logic                          r_in_cap;
    logic [epwr_pkg::VALUE_W-1:0]  r_in_value;

    // edge tracking state
    logic                          r_awaiting_fall;
    logic [COUNTER_BITS-1:0]       r_rise_time;
    logic [OVERFLOW_BITS-1:0]      r_tally;

    // width stage
    logic                          r_mid_v;
    logic [epwr_pkg::TICKS_W-1:0]  r_mid_ticks;
    logic                          r_mid_sat;

    // output register
    logic                          r_out_v;
    logic [epwr_pkg::TICKS_W-1:0]  r_out_ticks;
    logic [epwr_pkg::DIST_W-1:0]   r_out_dist;
    logic                          r_out_sat;

    logic                          out_en;
    logic                          mid_en;
    logic                          s1_go;
    logic                          in_take;

    logic [COUNTER_BITS-1:0]       val_cb;
    logic [OVERFLOW_BITS-1:0]      tally_inc;
    logic [TOT_W-1:0]              sum_raw;
    logic [TOT_W-1:0]              sum_adj;
    logic [TOT_W-1:0]              total;
    logic [epwr_pkg::TICKS_W-1:0]  n_ticks;
    logic                          is_fall;
    logic [PROD_W-1:0]             product;
    logic [PROD_W-FRAC_SHIFT-1:0]  prod_hi;
    logic [epwr_pkg::DIST_W-1:0]   n_dist;

    assign out_en  = !r_out_v || o_res.ready;
    assign mid_en  = !r_mid_v || out_en;
    assign s1_go   = r_in_v && mid_en;
    assign in_take = i_evt.valid && i_evt.ready;

    assign i_evt.ready = !r_in_v || s1_go;
    assign i_cfg.ready = 1'b1;

    // width computation on the registered event
    always_comb begin
        val_cb    = COUNTER_BITS'(r_in_value);
        tally_inc = (r_in_ovf && (r_tally != TALLY_MAX)) ? r_tally + 1'b1 : r_tally;
        is_fall   = r_in_cap && r_awaiting_fall;
        sum_raw   = TOT_W'({tally_inc, val_cb});
        // fall before rise without a counted wrap: assume the missed wrap
        if (sum_raw < TOT_W'(r_rise_time)) begin
            sum_adj = sum_raw + (TOT_W'(1) << COUNTER_BITS);
        end else begin
            sum_adj = sum_raw;
        end
        total = sum_adj - TOT_W'(r_rise_time);
        if (total > TOT_W'(epwr_pkg::TICKS_MAX)) begin
            n_ticks = epwr_pkg::TICKS_MAX;
        end else begin
            n_ticks = total[epwr_pkg::TICKS_W-1:0];
        end
    end

    // scale multiply on the width stage
    always_comb begin
        product = PROD_W'(r_mid_ticks) * PROD_W'(r_scale);
        prod_hi = product[PROD_W-1:FRAC_SHIFT];
        if (prod_hi > (PROD_W-FRAC_SHIFT)'(epwr_pkg::DIST_MAX)) begin
            n_dist = epwr_pkg::DIST_MAX;
        end else begin
            n_dist = prod_hi[epwr_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale         <= epwr_pkg::SCALE_RESET;
            r_in_v          <= 1'b0;
            r_awaiting_fall <= 1'b0;
            r_rise_time     <= '0;
            r_tally         <= '0;
            r_mid_v         <= 1'b0;
            r_out_v         <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_scale <= i_cfg.distance_scale_q24;
            end

            if (i_evt.ready) begin
                r_in_v <= i_evt.valid;
            end

            if (s1_go) begin
                // a rising edge restarts the wrap count
                if (r_in_cap && !r_awaiting_fall) begin
                    r_rise_time     <= val_cb;
                    r_tally         <= '0;
                    r_awaiting_fall <= 1'b1;
                end else begin
                    r_tally <= tally_inc;
                    if (r_in_cap) begin
                        r_awaiting_fall <= 1'b0;
                    end
                end
            end

            if (mid_en) begin
                r_mid_v <= s1_go && is_fall;
            end

            if (out_en) begin
                r_out_v <= r_mid_v;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_ovf   <= i_evt.overflow_event;
            r_in_cap   <= i_evt.capture_event;
            r_in_value <= i_evt.capture_value;
        end
        if (s1_go && is_fall) begin
            r_mid_ticks <= n_ticks;
            r_mid_sat   <= (tally_inc == TALLY_MAX);
        end
        if (out_en && r_mid_v) begin
            r_out_ticks <= r_mid_ticks;
            r_out_dist  <= n_dist;
            r_out_sat   <= r_mid_sat;
        end
    end

    assign o_res.valid           = r_out_v;
    assign o_res.pulse_ticks     = r_out_ticks;
    assign o_res.distance_cm     = r_out_dist;
    assign o_res.range_saturated = r_out_sat;

endmodule

// ===== hdl/epwr_checker.sv =====
// Port-level checks for echo_pulse_width_ranger_top, with its bind.
// Depends on epwr_pkg and the top level's ports.
module epwr_port_assert (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [epwr_pkg::TICKS_W-1:0]  i_pulse_ticks,
    input logic [epwr_pkg::DIST_W-1:0]   i_distance_cm,
    input logic                          i_range_saturated
);

    // hold a stalled result
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_pulse_ticks)
            && $stable(i_distance_cm) && $stable(i_range_saturated))
        else $error("result changed while stalled");

    // drop any result during reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // a zero width scales to zero distance
    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_pulse_ticks == '0) |-> (i_distance_cm == '0))
        else $error("nonzero distance for zero width");

endmodule

bind echo_pulse_width_ranger_top epwr_port_assert u_port_assert (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_pulse_ticks    (o_res.pulse_ticks),
    .i_distance_cm    (o_res.distance_cm),
    .i_range_saturated(o_res.range_saturated)
);
